// ----- sv/mlt_pkg.sv -----
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types, codes and helpers of the MAC learning table with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package mlt_pkg;

    // Default sizing of the table.
    localparam int DEF_ENTRIES   = 256;
    localparam int DEF_TIME_BITS = 32;

    // Configuration port geometry: registers at 8-byte spacing, 64-bit data.
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 64;

    // Address constants.
    localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] IPV4_MCAST_OUI = 24'h01_00_5E;

    localparam logic [7:0] ANNOUNCE_LIMIT_RESET = 8'hFF;
    localparam logic [8:0] REMOVED_MAX = 9'h1FF;

    typedef enum logic [2:0] {
        CMD_LEARN_REMOTE = 3'd0,
        CMD_LEARN_LOCAL  = 3'd1,
        CMD_LOOKUP       = 3'd2,
        CMD_AGE_SWEEP    = 3'd3,
        CMD_REMOVE_OWNER = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        STS_ADDED     = 3'd0,
        STS_REFRESHED = 3'd1,
        STS_PRESENT   = 3'd2,
        STS_IGNORED   = 3'd3,
        STS_FULL      = 3'd4,
        STS_FOUND     = 3'd5,
        STS_NOT_FOUND = 3'd6,
        STS_DONE      = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        REG_OWN_ADDRESS    = 2'd0,
        REG_AGE_LIMIT      = 2'd1,
        REG_ANNOUNCE_LIMIT = 2'd2
    } t_reg_index;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_RESP
    } t_state;

    // Table entry without its timestamp, whose width is a parameter.
    typedef struct packed {
        logic        valid;
        logic        is_local;
        logic [47:0] host;
        logic [47:0] owner;
    } t_entry_key;

    // Per-entry verdict of the compare unit.
    typedef struct packed {
        logic host_hit;
        logic free;
        logic stale_drop;
        logic keep_local;
        logic owner_drop;
    } t_eval;

    // One result beat.
    typedef struct packed {
        t_status     status;
        logic [47:0] found_owner;
        logic [7:0]  local_count;
        logic        announce_changed;
        logic [8:0]  removed_count;
    } t_result;

    // Broadcast, zero and IPv4 multicast hosts are never learned.
    function automatic logic mlt_addr_ignored(input logic [47:0] a);
        logic res;
        res = (a == MAC_BROADCAST) || (a == '0) ||
              ((a[47:24] == IPV4_MCAST_OUI) && !a[23]);
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mlt_if.sv -----
// ----------------------------------------------------------------------------
// mlt_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [47:0] host_address;
    logic [47:0] owner_address;
    logic [31:0] now;

    modport source (output valid, command, host_address, owner_address, now,
                    input ready);
    modport sink (input valid, command, host_address, owner_address, now,
                  output ready);
endinterface

interface mlt_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [47:0] found_owner;
    logic [7:0]  local_count;
    logic        announce_changed;
    logic [8:0]  removed_count;

    modport source (output valid, status, found_owner, local_count,
                    announce_changed, removed_count,
                    input ready);
    modport sink (input valid, status, found_owner, local_count,
                  announce_changed, removed_count,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/mlt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mlt_cfg_regs
// APB-style register file holding own address, age limit and announce limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_cfg_regs
    import mlt_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output logic      [47:0]              o_own_address,
    output logic      [31:0]              o_age_limit,
    output logic      [7:0]               o_announce_limit
);

    logic [47:0] r_own_address;
    logic [31:0] r_age_limit;
    logic [7:0]  r_announce_limit;
    logic [1:0]  reg_index;
    logic        wr_fire;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign wr_fire   = psel && penable && pwrite && pready;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address    <= '0;
            r_age_limit      <= '0;
            r_announce_limit <= ANNOUNCE_LIMIT_RESET;
        end else if (wr_fire) begin
            case (reg_index)
                REG_OWN_ADDRESS:    r_own_address    <= pwdata[47:0];
                REG_AGE_LIMIT:      r_age_limit      <= pwdata[31:0];
                REG_ANNOUNCE_LIMIT: r_announce_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_index)
            REG_OWN_ADDRESS:    prdata = CFG_DATA_BITS'(r_own_address);
            REG_AGE_LIMIT:      prdata = CFG_DATA_BITS'(r_age_limit);
            REG_ANNOUNCE_LIMIT: prdata = CFG_DATA_BITS'(r_announce_limit);
            default:            prdata = '0;
        endcase
    end

    assign o_own_address    = r_own_address;
    assign o_age_limit      = r_age_limit;
    assign o_announce_limit = r_announce_limit;

endmodule

`default_nettype wire

// ----- sv/mlt_entry_eval.sv -----
// ----------------------------------------------------------------------------
// mlt_entry_eval
// Shared compare unit: judges one table entry against the current command.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_entry_eval
    import mlt_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire t_entry_key           i_entry,
    input  wire logic [TIME_BITS-1:0] i_stamp,
    input  wire logic [47:0]          i_host,
    input  wire logic [47:0]          i_owner,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic [47:0]          i_own_address,
    input  wire logic [31:0]          i_age_limit,
    output t_eval                     o_eval
);

    logic [TIME_BITS-1:0] age;
    logic                 stale;

    // Age wraps modulo the timestamp width.
    assign age   = i_now - i_stamp;
    assign stale = (32'(age) > i_age_limit) && (i_entry.host != i_own_address);

    always_comb begin
        o_eval.host_hit   = i_entry.valid && (i_entry.host == i_host);
        o_eval.free       = !i_entry.valid;
        o_eval.stale_drop = i_entry.valid && i_entry.is_local && stale;
        o_eval.keep_local = i_entry.valid && i_entry.is_local && !stale;
        o_eval.owner_drop = i_entry.valid && !i_entry.is_local &&
                            (i_entry.owner == i_owner);
    end

endmodule

`default_nettype wire

// ----- sv/mac_learning_table_aging.sv -----
// ----------------------------------------------------------------------------
// mac_learning_table_aging
// Host MAC table with learn, lookup, age sweep and remove-by-owner commands.
// ----------------------------------------------------------------------------
// Every valid command walks the table memory one entry per cycle through a
// single compare unit behind the registered read port. Lookups and learns
// that hit stop at the hit; lookups and learns without a hit, age sweeps and
// remove owner walk the whole table. Unused command codes skip the walk and
// answer with the done status. One command is worked at a time and a new
// command beat is taken once the previous result has moved into the output
// register. After reset the block clears the table entry by entry and
// accepts no command beat meanwhile; register writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_learning_table_aging
    import mlt_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    mlt_cmd_if.sink                       i_cmd_ch,
    mlt_res_if.source                     o_res_ch,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef struct packed {
        t_entry_key           key;
        logic [TIME_BITS-1:0] stamp;
    } t_entry;

    // Configuration.
    logic [47:0] own_address;
    logic [31:0] age_limit;
    logic [7:0]  announce_limit;

    mlt_cfg_regs u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_own_address    (own_address),
        .o_age_limit      (age_limit),
        .o_announce_limit (announce_limit)
    );

    // Table memory and its ports.
    t_entry          mem [ENTRIES];
    t_entry          r_rdata;
    logic            rd_en;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;

    // Sequencer and captured command.
    t_state               r_state, n_state;
    logic [AW-1:0]        r_addr, n_addr;
    logic                 r_issue_done, n_issue_done;
    logic                 r_chk_vld, n_chk_vld;
    logic [AW-1:0]        r_chk_addr, n_chk_addr;
    logic [2:0]           r_cmd, n_cmd;
    logic [47:0]          r_host, n_host;
    logic [47:0]          r_owner, n_owner;
    logic [TIME_BITS-1:0] r_now, n_now;

    // Scan results.
    logic                 r_hit, n_hit;
    logic [AW-1:0]        r_hit_addr, n_hit_addr;
    logic [47:0]          r_hit_owner, n_hit_owner;
    logic                 r_hit_local, n_hit_local;
    logic                 r_free, n_free;
    logic [AW-1:0]        r_free_addr, n_free_addr;
    logic [CW-1:0]        r_count, n_count;
    logic [8:0]           r_removed, n_removed;

    // Announce state and result registers.
    logic                 r_lsc, n_lsc;
    logic [7:0]           r_announced, n_announced;
    t_result              r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    t_eval                ev;
    logic                 scan_end;
    logic                 stop_on_hit;

    // Learn decision.
    logic                 is_local;
    logic [47:0]          new_owner;
    logic                 fin_wr;
    logic [AW-1:0]        fin_addr;
    t_entry               fin_entry;
    t_status              fin_status;
    logic                 fin_removed;
    logic                 fin_lsc;

    mlt_entry_eval #(
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .i_entry       (r_rdata.key),
        .i_stamp       (r_rdata.stamp),
        .i_host        (r_host),
        .i_owner       (r_owner),
        .i_now         (r_now),
        .i_own_address (own_address),
        .i_age_limit   (age_limit),
        .o_eval        (ev)
    );

    // Memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[r_addr];
        end
    end

    // End of the walk: last entry checked, or the hit for learn and lookup.
    assign stop_on_hit = (r_cmd == CMD_LEARN_REMOTE) || (r_cmd == CMD_LEARN_LOCAL) ||
                         (r_cmd == CMD_LOOKUP);
    assign scan_end    = r_chk_vld && ((r_chk_addr == LAST) || (stop_on_hit && ev.host_hit));

    // Learn outcome from the walk.
    always_comb begin
        is_local                 = (r_cmd == CMD_LEARN_LOCAL);
        new_owner                = is_local ? own_address : r_owner;
        fin_wr                   = 1'b0;
        fin_addr                 = r_hit_addr;
        fin_entry.key.valid      = 1'b1;
        fin_entry.key.is_local   = is_local;
        fin_entry.key.host       = r_host;
        fin_entry.key.owner      = new_owner;
        fin_entry.stamp          = r_now;
        fin_status               = STS_FULL;
        fin_removed              = 1'b0;
        fin_lsc                  = 1'b0;
        if (mlt_addr_ignored(r_host)) begin
            fin_status = STS_IGNORED;
        end else if (r_hit) begin
            if (is_local && (r_hit_owner == own_address)) begin
                fin_wr                 = 1'b1;
                fin_entry.key.is_local = r_hit_local;
                fin_entry.key.owner    = r_hit_owner;
                fin_status             = STS_REFRESHED;
            end else if (!is_local && (r_hit_owner == r_owner)) begin
                fin_status = STS_PRESENT;
            end else begin
                fin_wr      = 1'b1;
                fin_lsc     = is_local || (r_hit_owner == own_address);
                fin_removed = 1'b1;
                fin_status  = STS_ADDED;
            end
        end else if (r_free) begin
            fin_wr     = 1'b1;
            fin_addr   = r_free_addr;
            fin_lsc    = is_local;
            fin_status = STS_ADDED;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_ch.valid) begin
                    n_state = (i_cmd_ch.command > CMD_REMOVE_OWNER) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_res_ch.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Memory controls and the command ready output.
    always_comb begin
        rd_en             = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = r_chk_addr;
        wr_data           = r_rdata;
        i_cmd_ch.ready    = (r_state == S_IDLE);
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = '0;
            end
            S_SCAN: begin
                rd_en = !r_issue_done;
                if (r_chk_vld) begin
                    if (((r_cmd == CMD_AGE_SWEEP) && ev.stale_drop) ||
                        ((r_cmd == CMD_REMOVE_OWNER) && ev.owner_drop)) begin
                        wr_en               = 1'b1;
                        wr_data.key.valid   = 1'b0;
                    end
                end
            end
            S_FINISH: begin
                if ((r_cmd == CMD_LEARN_REMOTE) || (r_cmd == CMD_LEARN_LOCAL)) begin
                    wr_en   = fin_wr;
                    wr_addr = fin_addr;
                    wr_data = fin_entry;
                end
            end
            default: ;
        endcase
    end

    // Datapath register updates.
    always_comb begin
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_chk_vld    = rd_en;
        n_chk_addr   = r_addr;
        n_cmd        = r_cmd;
        n_host       = r_host;
        n_owner      = r_owner;
        n_now        = r_now;
        n_hit        = r_hit;
        n_hit_addr   = r_hit_addr;
        n_hit_owner  = r_hit_owner;
        n_hit_local  = r_hit_local;
        n_free       = r_free;
        n_free_addr  = r_free_addr;
        n_count      = r_count;
        n_removed    = r_removed;
        n_lsc        = r_lsc;
        n_announced  = r_announced;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_res_ch.ready;

        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + AW'(1);
            end
            S_IDLE: begin
                // Capture the command beat and start a fresh walk.
                if (i_cmd_ch.valid) begin
                    n_cmd        = i_cmd_ch.command;
                    n_host       = i_cmd_ch.host_address;
                    n_owner      = i_cmd_ch.owner_address;
                    n_now        = i_cmd_ch.now[TIME_BITS-1:0];
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    n_hit        = 1'b0;
                    n_free       = 1'b0;
                    n_count      = '0;
                    n_removed    = '0;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_addr = r_addr + AW'(1);
                    if (r_addr == LAST) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_chk_vld) begin
                    case (r_cmd)
                        CMD_LEARN_REMOTE, CMD_LEARN_LOCAL, CMD_LOOKUP: begin
                            if (ev.host_hit && !r_hit) begin
                                n_hit       = 1'b1;
                                n_hit_addr  = r_chk_addr;
                                n_hit_owner = r_rdata.key.owner;
                                n_hit_local = r_rdata.key.is_local;
                            end
                            if (ev.free && !r_free) begin
                                n_free      = 1'b1;
                                n_free_addr = r_chk_addr;
                            end
                        end
                        CMD_AGE_SWEEP: begin
                            if (ev.stale_drop) begin
                                n_lsc = 1'b1;
                                if (r_removed != REMOVED_MAX) begin
                                    n_removed = r_removed + 9'd1;
                                end
                            end
                            if (ev.keep_local) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_REMOVE_OWNER: begin
                            if (ev.owner_drop && (r_removed != REMOVED_MAX)) begin
                                n_removed = r_removed + 9'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FINISH: begin
                n_res        = '0;
                n_res.status = STS_DONE;
                case (r_cmd)
                    CMD_LEARN_REMOTE, CMD_LEARN_LOCAL: begin
                        n_res.status        = fin_status;
                        n_res.removed_count = {8'd0, fin_removed};
                        n_lsc               = r_lsc || fin_lsc;
                    end
                    CMD_LOOKUP: begin
                        n_res.status      = r_hit ? STS_FOUND : STS_NOT_FOUND;
                        n_res.found_owner = r_hit ? r_hit_owner : 48'd0;
                    end
                    CMD_AGE_SWEEP: begin
                        // Announce the surviving local count when the set changed.
                        if (r_lsc) begin
                            n_announced = (32'(r_count) > 32'(announce_limit)) ?
                                          announce_limit : 8'(r_count);
                            n_lsc                  = 1'b0;
                            n_res.announce_changed = 1'b1;
                        end
                        n_res.local_count   = n_announced;
                        n_res.removed_count = r_removed;
                    end
                    CMD_REMOVE_OWNER: begin
                        n_res.removed_count = r_removed;
                    end
                    default: ;
                endcase
            end
            S_RESP: begin
                if (!r_out_valid || o_res_ch.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_lsc        <= 1'b0;
            r_announced  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_chk_vld    <= n_chk_vld;
            r_lsc        <= n_lsc;
            r_announced  <= n_announced;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_chk_addr  <= n_chk_addr;
        r_cmd       <= n_cmd;
        r_host      <= n_host;
        r_owner     <= n_owner;
        r_now       <= n_now;
        r_hit       <= n_hit;
        r_hit_addr  <= n_hit_addr;
        r_hit_owner <= n_hit_owner;
        r_hit_local <= n_hit_local;
        r_free      <= n_free;
        r_free_addr <= n_free_addr;
        r_count     <= n_count;
        r_removed   <= n_removed;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // Result channel.
    assign o_res_ch.valid            = r_out_valid;
    assign o_res_ch.status           = r_out.status;
    assign o_res_ch.found_owner      = r_out.found_owner;
    assign o_res_ch.local_count      = r_out.local_count;
    assign o_res_ch.announce_changed = r_out.announce_changed;
    assign o_res_ch.removed_count    = r_out.removed_count;

endmodule

`default_nettype wire
